// ===== hw/rtl/gwe_pkg.sv =====
// Shared widths, constants and the result type of the Gaussian wavefunction evaluator.
`default_nettype none

package gwe_pkg;

  localparam int COORD_W     = 24;
  localparam int ALPHA_W     = 16;
  localparam int DRIFT_W     = 26;
  localparam int WAVE_W      = 32;
  localparam int DERIV_W     = 48;
  localparam int SUM_W       = 56;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 112;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int MAX_COORDS = 1024;

  localparam logic [63:0] SUM_COORD_CAP = (64'(MAX_COORDS) << 46) - 64'd1;
  localparam logic [63:0] SUM_WIDTH_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam logic [SUM_W-1:0] SUM_CAP =
      (SUM_COORD_CAP < SUM_WIDTH_MAX) ? SUM_COORD_CAP[SUM_W-1:0] : SUM_WIDTH_MAX[SUM_W-1:0];

  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic [3:0]         POLY_TERMS  = 4'd11;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd32768;

  typedef struct packed {
    logic [DERIV_W-1:0] deriv;
    logic [WAVE_W-1:0]  wave;
    logic [DRIFT_W-1:0] drift;
    logic               done;
    logic               sat;
  } gwe_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gaussian_wavefunction_eval.sv =====
// Top level of the Gaussian trial wavefunction evaluator.
//
//   Channel   Direction  Transfer when            Payload
//   in_*      slave      in_tvalid & in_tready    tdata coordinate, tlast last_coordinate
//   out_*     master     out_tvalid & out_tready  tdata drift/wave/derivative, tlast done,
//                                                 tuser saturated
//   cfg_*     write      cfg_wr_en                alpha
//
// A coordinate that does not close a configuration passes through S_ACC and S_DRIFT into the
// output register, and the next coordinate is taken only once its result has been handed on.
// The closing coordinate yields its result after the six-step reduction by ln2 and the eleven
// Horner steps, each a multiply and a reciprocal multiply by the term index on the shared
// multiplier; a flushed exponential skips the polynomial. Reset is synchronous and needs no
// clearing pass. The output register holds one result, so the next coordinate is taken while
// a result waits on a stalled out_tready.
`default_nettype none

module gaussian_wavefunction_eval (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [gwe_pkg::IN_TDATA_W-1:0]  in_tdata,   // [23:0] coordinate
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [gwe_pkg::OUT_TDATA_W-1:0] out_tdata,  // [25:0] drift_force,
                                                           // [57:26] wave_value,
                                                           // [105:58] alpha_derivative
  output logic                                 out_tlast,
  output logic      [0:0]                      out_tuser,  // [0] saturated
  input  wire logic                            cfg_wr_en,
  input  wire logic [gwe_pkg::ALPHA_W-1:0]     cfg_wr_data
);
  import gwe_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic               out_valid_r;
  gwe_res_t           out_res_r;
  logic               res_valid;
  logic               res_ready;
  gwe_res_t           res;

  gwe_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .alpha         (alpha_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_coordinate (in_tdata[COORD_W-1:0]),
    .in_last       (in_tlast),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.deriv, out_res_r.wave, out_res_r.drift};
  assign out_tlast  = out_res_r.done;
  assign out_tuser  = out_res_r.sat;

endmodule

`default_nettype wire

// ===== hw/rtl/gwe_mul.sv =====
// Shared registered unsigned multiplier used by the multiply steps of the sequencer.
`default_nettype none

module gwe_mul (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [gwe_pkg::MUL_A_W-1:0] a,
  input  wire logic [gwe_pkg::MUL_B_W-1:0] b,
  output logic      [gwe_pkg::MUL_P_W-1:0] q
);
  import gwe_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gwe_seq.sv =====
// Sequencer: sum of squares, drift, exponential and derivative on the shared multiplier.
`default_nettype none

module gwe_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [gwe_pkg::ALPHA_W-1:0] alpha,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [gwe_pkg::COORD_W-1:0] in_coordinate,
  input  wire logic                        in_last,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output gwe_pkg::gwe_res_t                res
);
  import gwe_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_DRIFT  = 4'd2;
  localparam logic [3:0] S_E1     = 4'd3;
  localparam logic [3:0] S_E2     = 4'd4;
  localparam logic [3:0] S_RED    = 4'd5;
  localparam logic [3:0] S_H_MUL  = 4'd6;
  localparam logic [3:0] S_H_LOAD = 4'd7;
  localparam logic [3:0] S_H_DIV  = 4'd8;
  localparam logic [3:0] S_PSI    = 4'd9;
  localparam logic [3:0] S_D1     = 4'd10;
  localparam logic [3:0] S_D2     = 4'd11;
  localparam logic [3:0] S_D3     = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  logic [3:0]         state_r, state_nxt;
  logic [COORD_W-1:0] mag_r, mag_nxt;
  logic               xneg_r, xneg_nxt;
  logic               last_r, last_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               ovf_r, ovf_nxt;
  logic [20:0]        ih_r, ih_nxt;
  logic               flush_r, flush_nxt;
  logic [37:0]        rem_r, rem_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [2:0]         red_cnt_r, red_cnt_nxt;
  logic [32:0]        p_r, p_nxt;
  logic [3:0]         n_r, n_nxt;
  logic [WAVE_W-1:0]  psi_r, psi_nxt;
  logic [55:0]        hp_r, hp_nxt;
  logic [DERIV_W-1:0] deriv_r, deriv_nxt;
  logic [DRIFT_W-1:0] drift_r, drift_nxt;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_q;

  logic [COORD_W-1:0] in_mag;
  logic [SUM_W:0]     sum_add;
  logic [41:0]        drift_mag;
  logic [41:0]        drift_v;
  logic [DRIFT_W-1:0] drift_now;
  logic [37:0]        red_div;
  logic [32:0]        recip_m;
  logic [2:0]         recip_sh;
  logic [31:0]        div_quo;
  logic [33:0]        psi_sum;
  logic [33:0]        psi_sh;
  logic [56:0]        prod;

  gwe_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_mag    = in_coordinate[COORD_W-1] ? (~in_coordinate + COORD_W'(1)) : in_coordinate;
  assign sum_add   = {1'b0, sum_r} + {10'b0, mul_q[46:0]};
  assign drift_mag = {mul_q[39:0], 2'b00};
  assign drift_v   = xneg_r ? drift_mag : (42'd0 - drift_mag);
  assign drift_now = drift_v[41:16];
  assign red_div   = 38'(LN2_Q32) << red_cnt_r;
  assign div_quo   = 32'(mul_q[64:32] >> recip_sh);
  assign psi_sum   = {1'b0, p_r} + (34'd1 << k_r[4:0]);
  assign psi_sh    = psi_sum >> ({1'b0, k_r[4:0]} + 6'd1);
  assign prod      = {1'b0, hp_r} + {25'b0, mul_q[63:32]};

  // Each reciprocal is ceil(2^(32+sh)/n), which gives the exact quotient of any 32-bit dividend.
  always_comb begin
    unique case (n_r)
      4'd2: begin
        recip_m  = 33'd4294967296;
        recip_sh = 3'd1;
      end
      4'd3: begin
        recip_m  = 33'd5726623062;
        recip_sh = 3'd2;
      end
      4'd4: begin
        recip_m  = 33'd4294967296;
        recip_sh = 3'd2;
      end
      4'd5: begin
        recip_m  = 33'd6871947674;
        recip_sh = 3'd3;
      end
      4'd6: begin
        recip_m  = 33'd5726623062;
        recip_sh = 3'd3;
      end
      4'd7: begin
        recip_m  = 33'd4908534053;
        recip_sh = 3'd3;
      end
      4'd8: begin
        recip_m  = 33'd4294967296;
        recip_sh = 3'd3;
      end
      4'd9: begin
        recip_m  = 33'd7635497416;
        recip_sh = 3'd4;
      end
      4'd10: begin
        recip_m  = 33'd6871947674;
        recip_sh = 3'd4;
      end
      4'd11: begin
        recip_m  = 33'd6247225158;
        recip_sh = 3'd4;
      end
      default: begin
        recip_m  = 33'd4294967296;
        recip_sh = 3'd0;
      end
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_IDLE: begin
        mul_en = 1'b1;
        mul_a  = {9'b0, in_mag};
        mul_b  = {8'b0, in_mag};
      end
      S_ACC: begin
        mul_en = 1'b1;
        mul_a  = {17'b0, alpha};
        mul_b  = {8'b0, mag_r};
      end
      S_DRIFT: begin
        mul_en = last_r;
        mul_a  = {17'b0, alpha};
        mul_b  = {8'b0, sum_r[55:32]};
      end
      S_E1: begin
        mul_en = 1'b1;
        mul_a  = {17'b0, alpha};
        mul_b  = sum_r[31:0];
      end
      S_H_MUL: begin
        mul_en = 1'b1;
        mul_a  = p_r;
        mul_b  = rem_r[31:0];
      end
      S_H_LOAD: begin
        mul_en = 1'b1;
        mul_a  = recip_m;
        mul_b  = mul_q[63:32];
      end
      S_D1: begin
        mul_en = 1'b1;
        mul_a  = {9'b0, sum_r[55:32]};
        mul_b  = psi_r;
      end
      S_D2: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, sum_r[31:0]};
        mul_b  = psi_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res.drift = drift_r;
    res.wave  = psi_r;
    res.deriv = deriv_r;
    res.done  = 1'b1;
    res.sat   = ovf_r;
    if (state_r == S_DRIFT && !last_r) begin
      res_valid = 1'b1;
      res.drift = drift_now;
      res.wave  = '0;
      res.deriv = '0;
      res.done  = 1'b0;
    end else if (state_r == S_FIN) begin
      res_valid = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    xneg_nxt    = xneg_r;
    last_nxt    = last_r;
    sum_nxt     = sum_r;
    ovf_nxt     = ovf_r;
    ih_nxt      = ih_r;
    flush_nxt   = flush_r;
    rem_nxt     = rem_r;
    k_nxt       = k_r;
    red_cnt_nxt = red_cnt_r;
    p_nxt       = p_r;
    n_nxt       = n_r;
    psi_nxt     = psi_r;
    hp_nxt      = hp_r;
    deriv_nxt   = deriv_r;
    drift_nxt   = drift_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_mag;
          xneg_nxt  = in_coordinate[COORD_W-1];
          last_nxt  = in_last;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (sum_add > {1'b0, SUM_CAP}) begin
          sum_nxt = SUM_CAP;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = sum_add[SUM_W-1:0];
        end
        state_nxt = S_DRIFT;
      end
      S_DRIFT: begin
        if (last_r) begin
          drift_nxt = drift_now;
          state_nxt = S_E1;
        end else if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_E1: begin
        ih_nxt    = mul_q[20:0];
        flush_nxt = |mul_q[39:21];
        state_nxt = (|mul_q[39:21]) ? S_PSI : S_E2;
      end
      S_E2: begin
        rem_nxt     = {1'b0, ih_r, 16'b0} + {6'b0, mul_q[47:16]};
        k_nxt       = '0;
        red_cnt_nxt = 3'd5;
        state_nxt   = S_RED;
      end
      S_RED: begin
        if (rem_r >= red_div) begin
          rem_nxt            = rem_r - red_div;
          k_nxt[red_cnt_r]   = 1'b1;
        end
        red_cnt_nxt = red_cnt_r - 3'd1;
        if (red_cnt_r == 3'd0) begin
          flush_nxt = k_nxt[5];
          p_nxt     = ONE_Q32;
          n_nxt     = POLY_TERMS;
          state_nxt = k_nxt[5] ? S_PSI : S_H_MUL;
        end
      end
      S_H_MUL: begin
        state_nxt = S_H_LOAD;
      end
      S_H_LOAD: begin
        state_nxt = S_H_DIV;
      end
      S_H_DIV: begin
        p_nxt     = ONE_Q32 - {1'b0, div_quo};
        n_nxt     = n_r - 4'd1;
        state_nxt = (n_r == 4'd1) ? S_PSI : S_H_MUL;
      end
      S_PSI: begin
        psi_nxt   = flush_r ? '0 : psi_sh[31:0];
        state_nxt = S_D1;
      end
      S_D1: begin
        state_nxt = S_D2;
      end
      S_D2: begin
        hp_nxt    = mul_q[55:0];
        state_nxt = S_D3;
      end
      S_D3: begin
        deriv_nxt = DERIV_W'(48'd0 - {6'b0, prod[56:15]});
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          sum_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    xneg_r    <= xneg_nxt;
    last_r    <= last_nxt;
    ih_r      <= ih_nxt;
    flush_r   <= flush_nxt;
    rem_r     <= rem_nxt;
    k_r       <= k_nxt;
    red_cnt_r <= red_cnt_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    psi_r     <= psi_nxt;
    hp_r      <= hp_nxt;
    deriv_r   <= deriv_nxt;
    drift_r   <= drift_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gwe_checker.sv =====
// Port-level checker for the Gaussian wavefunction evaluator and its bind.
`default_nettype none

module gwe_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic         out_tlast
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Only a closing result carries a wave value or a derivative.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tlast |-> out_tdata[105:26] == 80'd0)
    else $error("non-closing result carries wave value or derivative");

  // The wave value never exceeds one.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> out_tdata[57:26] <= 32'h8000_0000)
    else $error("wave value above one");

  // After each transfer the sequencer leaves its idle state, so no two transfers are back to back.
  assert property (@(posedge clk) disable iff (!rst_n)
      in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in consecutive cycles");

endmodule

bind gaussian_wavefunction_eval gwe_checker u_gwe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
